[src/wmsr_pkg.sv]
// Package for the middle-square Weyl-sequence range generator.
// Holds widths, the Weyl step, the action codes, the sequencer states and the divider status type.
// No dependencies.
`timescale 1ns / 1ps

package wmsr_pkg;

  localparam int STATE_W   = 64;
  localparam int HALF_W    = 32;
  localparam int LIMIT_W   = 31;
  localparam int DIV_CNT_W = $clog2(STATE_W);

  localparam logic [STATE_W-1:0] WEYL_STEP = 64'hb5ad_4ece_da1c_e2a9;

  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_CROSS,
    ST_SUM,
    ST_MIX,
    ST_DIV,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[src/weyl_middle_square_random_range.sv]
// Middle-square Weyl-sequence generator returning the new state modulo a limit.
// A seed item gives no result; a draw item shows its result after 2 multiplier
// passes, 2 add steps, one step of the bit-serial remainder unit per dividend
// bit and an output load. The block takes one item at a time: a new item is
// taken only when the sequencer is idle again after a draw, and a result still
// stalled at the output keeps the sequencer from going idle.
// Reset (rst_n, synchronous): mixing state, Weyl counter and control cleared.
`timescale 1ns / 1ps

module weyl_middle_square_random_range (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [wmsr_pkg::HALF_W-1:0]  in_seed_value,
  input  logic [wmsr_pkg::LIMIT_W-1:0] in_range_limit,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wmsr_pkg::LIMIT_W-1:0] out_drawn_value,
  output logic                         out_range_error
);

  localparam int HW = wmsr_pkg::HALF_W;
  localparam int SW = wmsr_pkg::STATE_W;
  localparam int LW = wmsr_pkg::LIMIT_W;

  wmsr_pkg::seq_state_t state_r, state_nxt;

  // architectural state
  logic [SW-1:0] x_r;        // mixing state
  logic [SW-1:0] w_r;        // Weyl counter
  logic [SW-1:0] acc_r;      // square accumulator
  logic [LW-1:0] limit_r;    // range limit of the draw in flight

  // result register
  logic          out_valid_r;
  logic [LW-1:0] out_val_r;
  logic          out_err_r;

  // sequencer outputs
  logic          accept;
  logic          mul_cross;
  logic          div_start;
  logic          out_load;

  logic [HW-1:0]   mul_b;
  logic [2*HW-1:0] mul_p;
  logic [SW-1:0]   sq_sum;
  logic [SW-1:0]   mixed;
  logic [SW-1:0]   x_swapped;

  wmsr_pkg::div_stat_t div_stat;
  logic [LW-1:0]       div_rem;

  // Take a new item only when the sequencer is idle.
  assign in_stall = (state_r != wmsr_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wmsr_pkg::ST_IDLE: begin
        if (accept && in_action == wmsr_pkg::ACT_DRAW) begin
          state_nxt = wmsr_pkg::ST_MUL_LO;
        end
      end
      wmsr_pkg::ST_MUL_LO:    state_nxt = wmsr_pkg::ST_MUL_CROSS;
      wmsr_pkg::ST_MUL_CROSS: state_nxt = wmsr_pkg::ST_SUM;
      wmsr_pkg::ST_SUM:       state_nxt = wmsr_pkg::ST_MIX;
      wmsr_pkg::ST_MIX:       state_nxt = wmsr_pkg::ST_DIV;
      wmsr_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = wmsr_pkg::ST_OUT;
        end
      end
      wmsr_pkg::ST_OUT: begin
        // Hold until the result register is free.
        if (!out_valid_r || !out_stall) begin
          state_nxt = wmsr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wmsr_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    mul_cross = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      wmsr_pkg::ST_MUL_CROSS: mul_cross = 1'b1;
      wmsr_pkg::ST_MIX:       div_start = 1'b1;
      wmsr_pkg::ST_OUT:       out_load  = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmsr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- squaring on the shared multiplier ----------------
  // x^2 mod 2^64 = lo*lo + (lo*hi << 33): the low product first, then the cross.
  assign mul_b = mul_cross ? x_r[SW-1:HW] : x_r[HW-1:0];

  wmsr_mul u_mul (
    .clk (clk),
    .a   (x_r[HW-1:0]),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign sq_sum    = acc_r + {mul_p[SW-HW-2:0], {(HW+1){1'b0}}};
  assign mixed     = acc_r + w_r;
  assign x_swapped = {mixed[HW-1:0], mixed[SW-1:HW]};

  always_ff @(posedge clk) begin
    if (state_r == wmsr_pkg::ST_MUL_CROSS) begin
      acc_r <= mul_p;               // capture lo*lo
    end else if (state_r == wmsr_pkg::ST_SUM) begin
      acc_r <= sq_sum;              // add the doubled cross term
    end
  end

  // Mixing state and Weyl counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      w_r <= '0;
    end else if (accept && in_action == wmsr_pkg::ACT_SEED) begin
      x_r <= {in_seed_value, in_seed_value};
      w_r <= '0;
    end else if (state_r == wmsr_pkg::ST_SUM) begin
      w_r <= w_r + wmsr_pkg::WEYL_STEP;
    end else if (state_r == wmsr_pkg::ST_MIX) begin
      x_r <= x_swapped;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      limit_r <= in_range_limit;
    end
  end

  // ---------------- remainder unit ----------------
  wmsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (x_swapped),
    .divisor  (limit_r),
    .stat     (div_stat),
    .rem      (div_rem)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // A zero limit flags an error and forces the value to zero.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_err_r <= (limit_r == '0);
      out_val_r <= (limit_r == '0) ? '0 : div_rem;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_val_r;
  assign out_range_error = out_err_r;

`ifndef ASSERT_OFF
  a_div_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wmsr_pkg::ST_DIV && div_stat.done) |=> state_r == wmsr_pkg::ST_OUT)
    else $error("remainder done did not move sequencer to output");

  a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == wmsr_pkg::ST_DIV)
    else $error("remainder unit busy outside the divide state");

  a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> out_drawn_value == '0)
    else $error("error result carries a nonzero value");

  a_value_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && !out_err_r) |-> out_val_r < limit_r)
    else $error("drawn value not below range limit");
`endif

endmodule

[src/wmsr_mul.sv]
// Shared 32x32 multiplier with a registered product.
// Depends on wmsr_pkg for the half-word width.
`timescale 1ns / 1ps

module wmsr_mul (
  input  logic                          clk,
  input  logic [wmsr_pkg::HALF_W-1:0]   a,
  input  logic [wmsr_pkg::HALF_W-1:0]   b,
  output logic [2*wmsr_pkg::HALF_W-1:0] p
);

  logic [2*wmsr_pkg::HALF_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

[src/wmsr_div.sv]
// Bit-serial restoring remainder unit: 64-bit dividend, 31-bit divisor.
// Depends on wmsr_pkg for widths and the status struct.
`timescale 1ns / 1ps

module wmsr_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [wmsr_pkg::STATE_W-1:0]   dividend,
  input  logic [wmsr_pkg::LIMIT_W-1:0]   divisor,
  output wmsr_pkg::div_stat_t            stat,
  output logic [wmsr_pkg::LIMIT_W-1:0]   rem
);

  logic [wmsr_pkg::STATE_W-1:0]   dvd_r;
  logic [wmsr_pkg::LIMIT_W-1:0]   rem_r;
  logic [wmsr_pkg::LIMIT_W-1:0]   rem_nxt;
  logic [wmsr_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic [wmsr_pkg::LIMIT_W:0]     rem_sh;
  logic [wmsr_pkg::LIMIT_W:0]     dsr_ext;

  // One quotient bit per cycle: shift in, subtract if it fits.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[wmsr_pkg::STATE_W-1]};
    dsr_ext = {1'b0, divisor};
    if (rem_sh >= dsr_ext) begin
      rem_nxt = wmsr_pkg::LIMIT_W'(rem_sh - dsr_ext);
    end else begin
      rem_nxt = rem_sh[wmsr_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      cnt_r <= '1;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == '0);
  assign rem       = rem_r;

endmodule
